>>> src/mbad_pkg.sv
// Shared constants, register indexes and control types of the masked block-average downsampler.
`default_nettype none
package mbad_pkg;

    localparam int DEF_MAX_FACTOR       = 16;
    localparam int DEF_MAX_LINE_SAMPLES = 2048;
    localparam int DEF_PIXEL_BITS       = 16;

    localparam int BF_W        = 5;
    localparam int NS_W        = 12;
    localparam int FL_W        = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LINES  = 2'd2;

    localparam logic [BF_W-1:0] BF_RESET = 5'd1;
    localparam logic [NS_W-1:0] NS_RESET = 12'd2048;
    localparam logic [FL_W-1:0] FL_RESET = 16'd65535;

    typedef struct packed {
        logic accept;
        logic rd;
        logic upd;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic last;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

>>> src/mbad_pix_if.sv
// Input channel: one pixel word with its valid bit.
`default_nettype none
interface mbad_pix_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;
    logic                         pixel_valid;

    modport source (output valid, output pixel_value, output pixel_valid, input ready);
    modport sink   (input valid, input pixel_value, input pixel_valid, output ready);
endinterface
`default_nettype wire

>>> src/mbad_avg_if.sv
// Output channel: one block average word with its flags.
`default_nettype none
interface mbad_avg_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] average_value;
    logic                         average_valid;
    logic                         frame_end;

    modport source (output valid, output average_value, output average_valid,
                    output frame_end, input ready);
    modport sink   (input valid, input average_value, input average_valid,
                    input frame_end, output ready);
endinterface
`default_nettype wire

>>> src/mbad_div.sv
// Bit-serial restoring divider for block sum magnitude over valid count.
`default_nettype none
module mbad_div #(
    parameter int SUM_W = 24,
    parameter int CNT_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_quotient
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? CNT_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

>>> src/mbad_ctrl.sv
// Controller state machine sequencing accept, column update, division and output load.
`default_nettype none
module mbad_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mbad_pkg::t_status i_status,
    input  wire logic              i_in_valid,
    output mbad_pkg::t_cmd         o_cmd
);
    import mbad_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.accept = 1'b1;
                if (i_in_valid) n_state = S_READ;
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = (i_status.in_range && i_status.last) ? S_DSTART : S_IDLE;
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                n_state       = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;
endmodule
`default_nettype wire

>>> src/mbad_dp.sv
// Datapath: configuration, raster counters, column stores, divider and output register.
`default_nettype none
module mbad_dp #(
    parameter int MAX_FACTOR       = 16,
    parameter int MAX_LINE_SAMPLES = 2048,
    parameter int PIXEL_BITS       = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [mbad_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [mbad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire mbad_pkg::t_cmd               i_cmd,
    output mbad_pkg::t_status                 o_status,
    mbad_pix_if.sink                          i_pix,
    mbad_avg_if.source                        o_avg
);
    import mbad_pkg::*;

    localparam int SIB_W = $clog2(MAX_FACTOR);
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int SP_W  = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int COL_W = $clog2(MAX_LINE_SAMPLES);
    localparam int CW    = SP_W + 2;
    localparam int LW    = FL_W + 2;
    localparam int SUM_W = PIXEL_BITS + 2 * $clog2(MAX_FACTOR);
    localparam int CNT_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

    logic [BF_W-1:0] r_bf;
    logic [NS_W-1:0] r_ns;
    logic [FL_W-1:0] r_fl;

    logic [FW-1:0]   f;
    logic [SP_W-1:0] ns;
    logic [FL_W-1:0] nl;

    always_comb begin
        if (r_bf == '0) begin
            f = FW'(1);
        end else if (32'(r_bf) > MAX_FACTOR) begin
            f = FW'(MAX_FACTOR);
        end else begin
            f = FW'(r_bf);
        end
        if (r_ns == '0) begin
            ns = SP_W'(1);
        end else if (32'(r_ns) > MAX_LINE_SAMPLES) begin
            ns = SP_W'(MAX_LINE_SAMPLES);
        end else begin
            ns = SP_W'(r_ns);
        end
        nl = (r_fl == '0) ? FL_W'(1) : r_fl;
    end

    logic [SP_W-1:0]  r_sp;
    logic [SIB_W-1:0] r_sib;
    logic [COL_W-1:0] r_col;
    logic [FL_W-1:0]  r_lp;
    logic [SIB_W-1:0] r_lib;

    logic [FW-1:0]   sib_inc;
    logic [FW-1:0]   lib_inc;
    logic [SP_W-1:0] sp_inc;
    logic [FL_W-1:0] lp_inc;
    logic [CW-1:0]   bs;
    logic [LW-1:0]   bl;
    logic            in_col;
    logic            in_row;
    logic            last_col;
    logic            last_row;
    logic            accept;

    assign sib_inc  = FW'(r_sib) + FW'(1);
    assign lib_inc  = FW'(r_lib) + FW'(1);
    assign sp_inc   = r_sp + SP_W'(1);
    assign lp_inc   = r_lp + FL_W'(1);
    assign bs       = CW'(r_sp) - CW'(r_sib);
    assign bl       = LW'(r_lp) - LW'(r_lib);
    assign in_col   = (bs + CW'(f)) <= CW'(ns);
    assign in_row   = (bl + LW'(f)) <= LW'(nl);
    assign last_col = (bs + CW'(f) + CW'(f)) > CW'(ns);
    assign last_row = (bl + LW'(f) + LW'(f)) > LW'(nl);
    assign accept   = i_cmd.accept && i_pix.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bf  <= BF_RESET;
            r_ns  <= NS_RESET;
            r_fl  <= FL_RESET;
            r_sp  <= '0;
            r_sib <= '0;
            r_col <= '0;
            r_lp  <= '0;
            r_lib <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_BLOCK_FACTOR
                                  || i_cfg_index == CFG_LINE_SAMPLES
                                  || i_cfg_index == CFG_FRAME_LINES)) begin
            case (i_cfg_index)
                CFG_BLOCK_FACTOR: r_bf <= i_cfg_data[BF_W-1:0];
                CFG_LINE_SAMPLES: r_ns <= i_cfg_data[NS_W-1:0];
                CFG_FRAME_LINES:  r_fl <= i_cfg_data[FL_W-1:0];
                default:          r_bf <= r_bf;
            endcase
            r_sp  <= '0;
            r_sib <= '0;
            r_col <= '0;
            r_lp  <= '0;
            r_lib <= '0;
        end else if (accept) begin
            if (sp_inc >= ns) begin
                r_sp  <= '0;
                r_sib <= '0;
                r_col <= '0;
                if (lp_inc >= nl) begin
                    r_lp  <= '0;
                    r_lib <= '0;
                end else begin
                    r_lp  <= lp_inc;
                    r_lib <= (lib_inc >= f) ? '0 : SIB_W'(lib_inc);
                end
            end else begin
                r_sp <= sp_inc;
                if (sib_inc >= f) begin
                    r_sib <= '0;
                    r_col <= r_col + COL_W'(1);
                end else begin
                    r_sib <= SIB_W'(sib_inc);
                end
            end
        end
    end

    logic                         r_in_range;
    logic                         r_last;
    logic                         r_first;
    logic                         r_fend;
    logic [COL_W-1:0]             r_addr;
    logic signed [PIXEL_BITS-1:0] r_pix;
    logic                         r_pvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_range <= 1'b0;
            r_last     <= 1'b0;
        end else if (accept) begin
            r_in_range <= in_col && in_row;
            r_last     <= (sib_inc == f) && (lib_inc == f);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_first  <= (r_sib == '0) && (r_lib == '0);
            r_fend   <= last_col && last_row;
            r_addr   <= r_col;
            r_pix    <= i_pix.pixel_value;
            r_pvalid <= i_pix.pixel_valid;
        end
    end

    logic signed [SUM_W-1:0] mem_sum [MAX_LINE_SAMPLES];
    logic        [CNT_W-1:0] mem_cnt [MAX_LINE_SAMPLES];
    logic signed [SUM_W-1:0] r_rd_sum;
    logic        [CNT_W-1:0] r_rd_cnt;
    logic signed [SUM_W-1:0] s_new;
    logic        [CNT_W-1:0] c_new;
    logic signed [SUM_W-1:0] pix_ext;

    assign pix_ext = {{(SUM_W - PIXEL_BITS){r_pix[PIXEL_BITS-1]}}, r_pix};
    assign s_new   = (r_first ? '0 : r_rd_sum) + (r_pvalid ? pix_ext : '0);
    assign c_new   = (r_first ? '0 : r_rd_cnt) + (r_pvalid ? CNT_W'(1) : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_sum <= mem_sum[r_addr];
            r_rd_cnt <= mem_cnt[r_addr];
        end
        if (i_cmd.upd && r_in_range) begin
            mem_sum[r_addr] <= s_new;
            mem_cnt[r_addr] <= c_new;
        end
    end

    logic signed [SUM_W-1:0] r_sum_fin;
    logic        [CNT_W-1:0] r_cnt_fin;
    logic                    r_fend_fin;
    logic                    neg;
    logic        [SUM_W-1:0] mag;
    logic                    div_done;
    logic        [SUM_W-1:0] quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_sum_fin  <= s_new;
            r_cnt_fin  <= c_new;
            r_fend_fin <= r_fend;
        end
    end

    assign neg = r_sum_fin[SUM_W-1];
    assign mag = neg ? SUM_W'(-r_sum_fin) : SUM_W'(r_sum_fin);

    mbad_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (r_cnt_fin),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    logic                         r_out_valid;
    logic signed [PIXEL_BITS-1:0] r_out_avg;
    logic                         r_out_avalid;
    logic                         r_out_fend;
    logic        [PIXEL_BITS-1:0] q_lo;

    assign q_lo = quo[PIXEL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_avg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_cnt_fin == '0) begin
                r_out_avg <= '0;
            end else begin
                r_out_avg <= neg ? -q_lo : q_lo;
            end
            r_out_avalid <= r_cnt_fin != '0;
            r_out_fend   <= r_fend_fin;
        end
    end

    assign i_pix.ready         = i_cmd.accept;
    assign o_avg.valid         = r_out_valid;
    assign o_avg.average_value = r_out_avg;
    assign o_avg.average_valid = r_out_avalid;
    assign o_avg.frame_end     = r_out_fend;

    assign o_status.in_range = r_in_range;
    assign o_status.last     = r_last;
    assign o_status.div_done = div_done;
    assign o_status.out_busy = r_out_valid;
endmodule
`default_nettype wire

>>> src/masked_block_average_downsampler_unit.sv
// Top level of the masked block-average downsampler.
// Pixels arrive in raster order and each whole block of block_factor by block_factor pixels
// gives one word: the mean of its valid pixels, truncated toward zero, with a valid flag and a
// frame-end flag on the bottom-right block of the frame. Each pixel word does a read-modify-write
// of its column entry through a memory with a registered read, and no new pixel is taken until
// that is done. The last pixel of a block also runs the bit-serial divider, one quotient bit
// per cycle, and then waits for any previous result to leave the output register. The column
// stores need no clearing pass after reset, because the first line of each block row writes
// its entries.
// Writing any of the three registers restarts the frame and must happen while the block is idle.
`default_nettype none
module masked_block_average_downsampler_unit #(
    parameter int MAX_FACTOR       = mbad_pkg::DEF_MAX_FACTOR,
    parameter int MAX_LINE_SAMPLES = mbad_pkg::DEF_MAX_LINE_SAMPLES,
    parameter int PIXEL_BITS       = mbad_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [mbad_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [mbad_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mbad_pix_if.sink                              i_pix,
    mbad_avg_if.source                            o_avg
);
    import mbad_pkg::*;

    t_cmd    cmd;
    t_status status;

    mbad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .i_in_valid (i_pix.valid),
        .o_cmd      (cmd)
    );

    mbad_dp #(
        .MAX_FACTOR       (MAX_FACTOR),
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
        .PIXEL_BITS       (PIXEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_pix       (i_pix),
        .o_avg       (o_avg)
    );
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the masked block-average downsampler, driven by directed and random frames.
`timescale 1ns / 100ps
module testbench;
    import mbad_pkg::*;

    localparam int PW            = DEF_PIXEL_BITS;
    localparam int HALF_PERIOD   = 4;
    localparam int LIMIT_NS      = 10_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PIXELS = 450;

    typedef struct packed {
        logic signed [PW-1:0] value;
        logic                 mask;
    } t_pixel_word;

    typedef struct packed {
        logic signed [PW-1:0] value;
        logic                 valid;
        logic                 frame_end;
    } t_block_avg;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BLOCK_FACTOR;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   drv_valid = 1'b0;
    logic signed [PW-1:0]   drv_value = '0;
    logic                   drv_mask  = 1'b0;
    logic                   rcv_ready = 1'b0;
    logic                   pix_taken = 1'b0;

    // Predicted registers and column stores of the block.
    logic [BF_W-1:0]    factor_reg = BF_RESET;
    logic [NS_W-1:0]    line_reg   = NS_RESET;
    logic [FL_W-1:0]    lines_reg  = FL_RESET;
    logic signed [23:0] col_sum [DEF_MAX_LINE_SAMPLES];
    logic [8:0]         col_cnt [DEF_MAX_LINE_SAMPLES];
    int                 sample_pos    = 0;
    int                 line_pos      = 0;
    int                 sample_in_blk = 0;
    int                 line_in_blk   = 0;

    t_pixel_word pixels_pending[$];
    t_block_avg  blocks_expected[$];
    int          results_seen = 0;
    int          mismatches   = 0;
    int          hold_left    = 0;
    bit          held_once    = 1'b0;

    mbad_pix_if #(.PIXEL_BITS(PW)) pix_ch ();
    mbad_avg_if #(.PIXEL_BITS(PW)) avg_ch ();

    assign pix_ch.valid       = drv_valid;
    assign pix_ch.pixel_value = drv_value;
    assign pix_ch.pixel_valid = drv_mask;
    assign avg_ch.ready       = rcv_ready;

    masked_block_average_downsampler_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix_ch),
        .o_avg       (avg_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int clamp_size(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Idles at random on either side, apart from a long calm stretch with no idling.
    function automatic bit idle_now();
        if (results_seen >= 30 && results_seen < 70) return 1'b0;
        return $urandom_range(0, 99) < 31;
    endfunction

    task automatic rewind_raster();
        sample_pos    = 0;
        line_pos      = 0;
        sample_in_blk = 0;
        line_in_blk   = 0;
    endtask

    task automatic fold_pixel(input logic signed [PW-1:0] value, input logic mask);
        int f, ns, nl, cols_out, rows_out, col, row, s, c, quotient;
        t_block_avg res;
        f        = clamp_size(int'(factor_reg), DEF_MAX_FACTOR);
        ns       = clamp_size(int'(line_reg), DEF_MAX_LINE_SAMPLES);
        nl       = clamp_size(int'(lines_reg), 65535);
        cols_out = ns / f;
        rows_out = nl / f;
        col      = sample_pos / f;
        row      = line_pos / f;
        if (col < cols_out && row < rows_out) begin
            if (line_in_blk == 0 && sample_in_blk == 0) begin
                s = 0;
                c = 0;
            end else begin
                s = int'(col_sum[col]);
                c = int'(col_cnt[col]);
            end
            if (mask) begin
                s += int'(value);
                c += 1;
            end
            col_sum[col] = s[23:0];
            col_cnt[col] = c[8:0];
            if (line_in_blk == f - 1 && sample_in_blk == f - 1) begin
                quotient = (c > 0) ? s / c : 0;
                res.value     = quotient[PW-1:0];
                res.valid     = (c > 0);
                res.frame_end = (row == rows_out - 1 && col == cols_out - 1);
                blocks_expected.push_back(res);
            end
        end
        sample_in_blk = (sample_in_blk + 1 >= f) ? 0 : sample_in_blk + 1;
        sample_pos++;
        if (sample_pos >= ns) begin
            sample_pos    = 0;
            sample_in_blk = 0;
            line_in_blk   = (line_in_blk + 1 >= f) ? 0 : line_in_blk + 1;
            line_pos++;
            if (line_pos >= nl) begin
                line_pos    = 0;
                line_in_blk = 0;
            end
        end
    endtask

    always @(posedge clk) begin : scoreboard
        t_block_avg want;
        t_block_avg got;
        pix_taken = pix_ch.valid && pix_ch.ready;
        if (rst_n) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BLOCK_FACTOR: begin
                        factor_reg = cfg_data[BF_W-1:0];
                        rewind_raster();
                    end
                    CFG_LINE_SAMPLES: begin
                        line_reg = cfg_data[NS_W-1:0];
                        rewind_raster();
                    end
                    CFG_FRAME_LINES: begin
                        lines_reg = cfg_data[FL_W-1:0];
                        rewind_raster();
                    end
                    default: ;
                endcase
            end
            if (pix_taken) begin
                fold_pixel(pix_ch.pixel_value, pix_ch.pixel_valid);
            end
            if (avg_ch.valid && avg_ch.ready) begin
                results_seen++;
                got.value     = avg_ch.average_value;
                got.valid     = avg_ch.average_valid;
                got.frame_end = avg_ch.frame_end;
                if (blocks_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, actual value %0d valid %0b frame_end %0b",
                             $time, $signed(got.value), got.valid, got.frame_end);
                end else begin
                    want = blocks_expected.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        $display("%0t: expected value %0d valid %0b frame_end %0b, actual %s",
                                 $time, $signed(want.value), want.valid, want.frame_end,
                                 $sformatf("value %0d valid %0b frame_end %0b",
                                           $signed(got.value), got.valid, got.frame_end));
                    end
                end
            end
        end
    end

    always @(negedge clk) begin : pixel_driver
        t_pixel_word word;
        if (rst_n && !(drv_valid && !pix_taken)) begin
            if (pixels_pending.size() != 0 && !idle_now()) begin
                word = pixels_pending.pop_front();
                drv_valid <= 1'b1;
                drv_value <= word.value;
                drv_mask  <= word.mask;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Once, the receiver holds off long enough for the block to fill and stall its input.
    always @(negedge clk) begin : average_receiver
        if (!held_once && results_seen >= 20) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rcv_ready <= 1'b0;
        end else begin
            rcv_ready <= !idle_now();
        end
    end

    task automatic push_pixel(input logic signed [PW-1:0] value, input logic mask);
        t_pixel_word word;
        word.value = value;
        word.mask  = mask;
        pixels_pending.push_back(word);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] factor, samples, lines,
                                input int first);
        for (int k = 0; k < 3; k++) begin
            case ((first + k) % 3)
                0: write_reg(CFG_BLOCK_FACTOR, factor);
                1: write_reg(CFG_LINE_SAMPLES, samples);
                default: write_reg(CFG_FRAME_LINES, lines);
            endcase
        end
    endtask

    // Pixels that end no block leave no result behind, so a settling pause follows.
    task automatic drain_phase();
        while (pixels_pending.size() != 0 || drv_valid) @(negedge clk);
        while (blocks_expected.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        int pick, fw, f_eff, cols, rows, ns_eff, nl_eff, frames, count, valid_pct;
        int random_pixels;
        logic [CFG_DATA_W-1:0] f_data, ns_data, nl_data;
        logic signed [PW-1:0] value;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_pixel(16'sh7FFF, 1'b1);
        push_pixel(16'sh8000, 1'b1);
        push_pixel(0, 1'b1);
        push_pixel(-1, 1'b1);
        push_pixel(1, 1'b1);
        push_pixel(12345, 1'b0);
        push_pixel(16'sh5555, 1'b1);
        push_pixel(16'shAAAA, 1'b1);
        drain_phase();

        set_geometry(16'd2, 16'd4, 16'd2, 0);
        push_pixel(-3, 1'b1);
        push_pixel(-4, 1'b1);
        push_pixel(100, 1'b0);
        push_pixel(200, 1'b0);
        push_pixel(7, 1'b0);
        push_pixel(-9, 1'b0);
        push_pixel(16'sh7FFF, 1'b0);
        push_pixel(16'sh8000, 1'b0);
        drain_phase();

        set_geometry(16'd0, 16'd2, 16'd0, 1);
        push_pixel(5, 1'b1);
        push_pixel(6, 1'b1);
        push_pixel(7, 1'b0);
        push_pixel(8, 1'b1);
        drain_phase();

        set_geometry(16'hFFE3, 16'd2, 16'd5, 2);
        push_pixel(11, 1'b1);
        push_pixel(-12, 1'b1);
        push_pixel(13, 1'b1);
        drain_phase();

        set_geometry(16'd1, 16'd0, 16'd3, 0);
        push_pixel(-100, 1'b1);
        push_pixel(200, 1'b1);
        push_pixel(-300, 1'b1);
        drain_phase();

        set_geometry(16'd1, 16'hFFFF, 16'd1, 1);
        for (int i = 0; i < 64; i++) begin
            push_pixel(PW'($urandom()), $urandom_range(0, 4) != 0);
        end
        drain_phase();

        set_geometry(16'd16, 16'd16, 16'd16, 2);
        for (int i = 0; i < 256; i++) push_pixel(16'sh7FFF, 1'b1);
        drain_phase();
        set_geometry(16'h001F, 16'd16, 16'hFFFF, 0);
        for (int i = 0; i < 256; i++) push_pixel(16'sh8000, 1'b1);
        drain_phase();

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 99);
            if (pick < 7) fw = 0;
            else if (pick < 15) fw = $urandom_range(16, 31);
            else if (pick < 25) fw = $urandom_range(5, 15);
            else fw = $urandom_range(1, 4);
            f_eff  = clamp_size(fw, DEF_MAX_FACTOR);
            cols   = (f_eff >= 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            rows   = (f_eff >= 8) ? 1 : $urandom_range(1, 3);
            ns_eff = cols * f_eff + $urandom_range(0, (f_eff >= 8) ? 3 : f_eff - 1);
            nl_eff = rows * f_eff + $urandom_range(0, (f_eff >= 8) ? 1 : f_eff - 1);
            f_data  = CFG_DATA_W'(fw);
            ns_data = CFG_DATA_W'(ns_eff);
            nl_data = CFG_DATA_W'(nl_eff);
            if ($urandom_range(0, 3) == 0) f_data |= CFG_DATA_W'($urandom()) & 16'hFFE0;
            if ($urandom_range(0, 3) == 0) ns_data |= CFG_DATA_W'($urandom()) & 16'hF000;
            if ($urandom_range(0, 19) == 0) begin
                ns_data = '0;
                ns_eff  = 1;
            end
            if ($urandom_range(0, 19) == 0) begin
                nl_data = '0;
                nl_eff  = 1;
            end
            set_geometry(f_data, ns_data, nl_data, $urandom_range(0, 2));
            frames = (f_eff >= 8) ? 1 : $urandom_range(1, 2);
            count  = frames * ns_eff * nl_eff;
            if ($urandom_range(0, 3) == 0) count += $urandom_range(0, ns_eff * nl_eff - 1);
            if (count > RANDOM_PIXELS - random_pixels) count = RANDOM_PIXELS - random_pixels;
            case ($urandom_range(0, 4))
                0: valid_pct = 0;
                1: valid_pct = 15;
                2: valid_pct = 50;
                3: valid_pct = 85;
                default: valid_pct = 100;
            endcase
            for (int i = 0; i < count; i++) begin
                case ($urandom_range(0, 15))
                    0: value = 16'sh8000;
                    1: value = 16'sh7FFF;
                    2: value = '0;
                    3: value = -1;
                    default: value = PW'($urandom());
                endcase
                push_pixel(value, $urandom_range(0, 99) < valid_pct);
            end
            random_pixels += count;
            drain_phase();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
